// ===== hdl/ltwrd_pkg.sv =====
// Shared constants for the lux to warm RGB dimmer.
package ltwrd_pkg;

  localparam int COEFF_FRAC_BITS = 16;
  localparam int LUX_W           = 16;
  localparam int PWM_W           = 10;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;

  localparam logic [PWM_W-1:0] BASE_RED   = PWM_W'(100);
  localparam logic [PWM_W-1:0] BASE_GREEN = PWM_W'(200);
  localparam logic [PWM_W-1:0] BASE_BLUE  = PWM_W'(900);

  localparam logic             RST_RGB_ENABLED   = 1'b1;
  localparam logic [LUX_W-1:0] RST_LUX_MIN       = LUX_W'(0);
  localparam logic [LUX_W-1:0] RST_LUX_MAX       = LUX_W'(3000);
  localparam logic [LUX_W-1:0] RST_DEADBAND      = LUX_W'(50);
  localparam logic [LUX_W-1:0] RST_OFF_THRESHOLD = LUX_W'(2300);
  localparam logic [LUX_W-1:0] RST_ON_THRESHOLD  = LUX_W'(1800);
  localparam logic [PWM_W-1:0] RST_PWM_MAX       = PWM_W'(999);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RGB_ENABLED   = 3'd0,
    REG_LUX_MIN       = 3'd1,
    REG_LUX_MAX       = 3'd2,
    REG_DEADBAND      = 3'd3,
    REG_OFF_THRESHOLD = 3'd4,
    REG_ON_THRESHOLD  = 3'd5,
    REG_PWM_MAX       = 3'd6
  } cfg_reg_t;

endpackage

// ===== hdl/lux_to_warm_rgb_dimmer.sv =====
// A request that is neither forced off nor in the deadband runs through the bit-serial divider
//   (skipped when lux_max <= lux_min), the squaring multiplier and the 10-bit blend multipliers
//   one after another; in_stall holds off a new request until the control returns to ST_IDLE.
// Forced-off results skip the arithmetic; disabled or deadband requests free the input without a
//   result. The output register lets a new request in while held. Synchronous reset restores the
//   config registers to defaults and clears out_valid, hysteresis and deadband state.
module lux_to_warm_rgb_dimmer #(
  parameter int COEFF_FRAC_BITS = ltwrd_pkg::COEFF_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ltwrd_pkg::LUX_W-1:0]      lux_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [ltwrd_pkg::PWM_W-1:0]      red_compare,
  output logic [ltwrd_pkg::PWM_W-1:0]      green_compare,
  output logic [ltwrd_pkg::PWM_W-1:0]      blue_compare,
  input  logic                             cfg_we,
  input  logic [ltwrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ltwrd_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int LW = ltwrd_pkg::LUX_W;
  localparam int PW = ltwrd_pkg::PWM_W;
  localparam int CW = COEFF_FRAC_BITS + 1;
  localparam logic [CW-1:0] COEFF_ONE = CW'(1) << COEFF_FRAC_BITS;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_CLAMP = 7'b0000010,
    ST_CHECK = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_SQR   = 7'b0010000,
    ST_BLEND = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  function automatic logic [PW-1:0] headroom(input logic [PW-1:0] pmax,
                                             input logic [PW-1:0] base);
    headroom = (pmax > base) ? pmax - base : '0;
  endfunction

  state_t state;

  logic          rgb_enabled;
  logic [LW-1:0] lux_min;
  logic [LW-1:0] lux_max;
  logic [LW-1:0] deadband;
  logic [LW-1:0] off_threshold;
  logic [LW-1:0] on_threshold;
  logic [PW-1:0] pwm_max;

  logic          off_latched;
  logic          have_last;
  logic [LW-1:0] applied_lux;

  logic [LW-1:0] lux_r;
  logic [LW-1:0] lux_c;
  logic [PW-1:0] res_red;
  logic [PW-1:0] res_green;
  logic [PW-1:0] res_blue;

  logic          accept;
  logic          out_free;
  logic [LW-1:0] lux_lo;
  logic [LW-1:0] lux_cl;
  logic          off_latched_next;
  logic [LW-1:0] lux_gap;
  logic          in_band;
  logic          span_empty;
  logic          go_on;

  logic          div_start;
  logic          div_done;
  logic [CW-1:0] div_quo;

  logic            sq_start;
  logic            sq_done;
  logic [CW-1:0]   sq_a;
  logic [2*CW-1:0] sq_prod;
  logic [CW-1:0]   sq;

  logic             bl_start;
  logic             bl_done;
  logic             bl_done_g;
  logic             bl_done_b;
  logic [CW+PW-1:0] prod_red;
  logic [CW+PW-1:0] prod_green;
  logic [CW+PW-1:0] prod_blue;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // raise to min first, then cap at max
  assign lux_lo = (lux_r < lux_min) ? lux_min : lux_r;
  assign lux_cl = (lux_lo > lux_max) ? lux_max : lux_lo;

  always_comb begin
    off_latched_next = off_latched;
    if (!off_latched && lux_c >= off_threshold) begin
      off_latched_next = 1'b1;
    end else if (off_latched && lux_c <= on_threshold) begin
      off_latched_next = 1'b0;
    end
  end

  assign lux_gap    = (lux_c >= applied_lux) ? lux_c - applied_lux : applied_lux - lux_c;
  assign in_band    = have_last && (lux_gap < deadband);
  assign span_empty = (lux_max <= lux_min);
  assign go_on      = (state == ST_CHECK) && !off_latched_next && !in_band;

  assign div_start = go_on && !span_empty;
  assign sq_start  = (go_on && span_empty) || ((state == ST_DIV) && div_done);
  assign sq_a      = (state == ST_DIV) ? div_quo : COEFF_ONE;
  assign sq        = sq_prod[COEFF_FRAC_BITS +: CW];
  assign bl_start  = (state == ST_SQR) && sq_done;

  ltwrd_serial_div #(.QW(CW), .DW(LW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (lux_c - lux_min),
    .den   (lux_max - lux_min),
    .done  (div_done),
    .quo   (div_quo)
  );

  ltwrd_serial_mul #(.AW(CW), .BW(CW)) u_sq (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .a     (sq_a),
    .b     (sq_a),
    .done  (sq_done),
    .prod  (sq_prod)
  );

  ltwrd_serial_mul #(.AW(CW), .BW(PW)) u_blend_red (
    .clk   (clk),
    .rst   (rst),
    .start (bl_start),
    .a     (sq),
    .b     (headroom(pwm_max, ltwrd_pkg::BASE_RED)),
    .done  (bl_done),
    .prod  (prod_red)
  );

  ltwrd_serial_mul #(.AW(CW), .BW(PW)) u_blend_green (
    .clk   (clk),
    .rst   (rst),
    .start (bl_start),
    .a     (sq),
    .b     (headroom(pwm_max, ltwrd_pkg::BASE_GREEN)),
    .done  (bl_done_g),
    .prod  (prod_green)
  );

  ltwrd_serial_mul #(.AW(CW), .BW(PW)) u_blend_blue (
    .clk   (clk),
    .rst   (rst),
    .start (bl_start),
    .a     (sq),
    .b     (headroom(pwm_max, ltwrd_pkg::BASE_BLUE)),
    .done  (bl_done_b),
    .prod  (prod_blue)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      off_latched   <= 1'b0;
      have_last     <= 1'b0;
      applied_lux   <= '0;
      rgb_enabled   <= ltwrd_pkg::RST_RGB_ENABLED;
      lux_min       <= ltwrd_pkg::RST_LUX_MIN;
      lux_max       <= ltwrd_pkg::RST_LUX_MAX;
      deadband      <= ltwrd_pkg::RST_DEADBAND;
      off_threshold <= ltwrd_pkg::RST_OFF_THRESHOLD;
      on_threshold  <= ltwrd_pkg::RST_ON_THRESHOLD;
      pwm_max       <= ltwrd_pkg::RST_PWM_MAX;
    end else begin
      if (cfg_we) begin
        unique case (ltwrd_pkg::cfg_reg_t'(cfg_index))
          ltwrd_pkg::REG_RGB_ENABLED:   rgb_enabled   <= cfg_data[0];
          ltwrd_pkg::REG_LUX_MIN:       lux_min       <= cfg_data[LW-1:0];
          ltwrd_pkg::REG_LUX_MAX:       lux_max       <= cfg_data[LW-1:0];
          ltwrd_pkg::REG_DEADBAND:      deadband      <= cfg_data[LW-1:0];
          ltwrd_pkg::REG_OFF_THRESHOLD: off_threshold <= cfg_data[LW-1:0];
          ltwrd_pkg::REG_ON_THRESHOLD:  on_threshold  <= cfg_data[LW-1:0];
          ltwrd_pkg::REG_PWM_MAX:       pwm_max       <= cfg_data[PW-1:0];
          default: ;
        endcase
      end

      // ST_OUT reloads the output register itself
      if (out_valid && !out_stall && state != ST_OUT) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          // disabled: the request is taken and dropped
          if (accept && rgb_enabled) begin
            state <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          off_latched <= off_latched_next;
          if (off_latched_next) begin
            state <= ST_OUT;
          end else if (in_band) begin
            state <= ST_IDLE;
          end else begin
            applied_lux <= lux_c;
            have_last   <= 1'b1;
            state       <= span_empty ? ST_SQR : ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_SQR;
          end
        end
        ST_SQR: begin
          if (sq_done) begin
            state <= ST_BLEND;
          end
        end
        ST_BLEND: begin
          if (bl_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      lux_r <= lux_sample;
    end
    if (state == ST_CLAMP) begin
      lux_c <= lux_cl;
    end
    if (state == ST_CHECK && off_latched_next) begin
      res_red   <= pwm_max;
      res_green <= pwm_max;
      res_blue  <= pwm_max;
    end
    if (state == ST_BLEND && bl_done) begin
      res_red   <= ltwrd_pkg::BASE_RED + prod_red[COEFF_FRAC_BITS +: PW];
      res_green <= ltwrd_pkg::BASE_GREEN + prod_green[COEFF_FRAC_BITS +: PW];
      res_blue  <= ltwrd_pkg::BASE_BLUE + prod_blue[COEFF_FRAC_BITS +: PW];
    end
    if (state == ST_OUT && out_free) begin
      red_compare   <= res_red;
      green_compare <= res_green;
      blue_compare  <= res_blue;
    end
  end

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_sq_done_in_sqr: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> state == ST_SQR)
    else $error("square finished outside the square phase");

  a_blend_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    (bl_done == bl_done_g) && (bl_done == bl_done_b) && (!bl_done || state == ST_BLEND))
    else $error("blend lanes out of step");

  a_out_from_out_state: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_OUT)
    else $error("result raised outside the output phase");

endmodule

// ===== hdl/ltwrd_serial_div.sv =====
// Restoring divider, one quotient bit per cycle, for num <= den.
module ltwrd_serial_div #(
  parameter int QW = ltwrd_pkg::COEFF_FRAC_BITS + 1,
  parameter int DW = ltwrd_pkg::LUX_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [QW-1:0] quo
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic          first;
  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic [DW:0]   trial_sub;
  logic          ge;

  // first step takes the integer bit without shifting
  assign trial     = first ? {1'b0, rem} : {rem, 1'b0};
  assign ge        = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(QW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= num;
      den_r <= den;
      first <= 1'b1;
      quo   <= '0;
    end else if (busy) begin
      rem   <= ge ? trial_sub[DW-1:0] : trial[DW-1:0];
      first <= 1'b0;
      quo   <= {quo[QW-2:0], ge};
    end
  end

endmodule

// ===== hdl/ltwrd_serial_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle.
module ltwrd_serial_mul #(
  parameter int AW = ltwrd_pkg::COEFF_FRAC_BITS + 1,
  parameter int BW = ltwrd_pkg::PWM_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);

  localparam int CW = $clog2(BW + 1);

  logic [AW-1:0] a_r;
  logic [AW-1:0] hi;
  logic [BW-1:0] lo;
  logic          busy;
  logic [CW-1:0] cnt;
  logic [AW:0]   sum;

  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, a_r} : {(AW + 1){1'b0}});
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(BW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      hi  <= '0;
      lo  <= b;
    end else if (busy) begin
      hi <= sum[AW:1];
      lo <= {sum[0], lo[BW-1:1]};
    end
  end

endmodule
